>>> src/mjpo_pkg.sv
package mjpo_pkg;

    localparam int MAX_SIZE  = 64;
    localparam int MAX_RANKS = MAX_SIZE / 2;
    localparam int RANK_W    = $clog2(MAX_RANKS);
    localparam int SIZE_W    = 7;
    localparam int STEP_W    = 6;
    localparam int VAL_W     = 8;
    localparam int DEST_W    = 7;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int QDEPTH    = 2;

    localparam logic [1:0] REG_MATRIX_SIZE = 2'd0;
    localparam logic [1:0] REG_COMM_ENABLE = 2'd1;

    // One queued tick, already classified by the front end.
    typedef struct packed {
        logic              init;
        logic              comm;
        logic [SIZE_W-1:0] size;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic [VAL_W-1:0] pf;
        logic [VAL_W-1:0] ps;
        logic [VAL_W-1:0] sf;
        logic [VAL_W-1:0] ss;
    } adv_t;

    // One step of the per-rank pair update, all values wrapping in eight bits.
    function automatic adv_t advance(logic [VAL_W-1:0] pf, logic [VAL_W-1:0] ps,
                                     logic [VAL_W-1:0] sf, logic [VAL_W-1:0] ss,
                                     logic [SIZE_W-1:0] n1, logic [SIZE_W-2:0] n2);
        adv_t             res;
        logic [VAL_W:0]   sum;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
        res.pf = pf;
        res.ps = ps;
        res.sf = sf;
        res.ss = ss;
        sum    = {1'b0, sf} + {1'b0, ss};
        if (sum >= {{(VAL_W+1-SIZE_W){1'b0}}, n1}) begin
            a = sf + 8'd1;
            if (a == ss) begin
                a      = a - {{(VAL_W-SIZE_W+1){1'b0}}, n2};
                res.ss = a;
            end
            res.sf = a;
            res.pf = a;
        end else begin
            b      = ss + 8'd1;
            res.ss = b;
            res.ps = b;
        end
        return res;
    endfunction

endpackage

>>> src/mjpo_front.sv
module mjpo_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_full,
    input  logic                          restart,
    input  logic [mjpo_pkg::SIZE_W-1:0]   size,
    input  logic                          comm,
    output logic                          push,
    output mjpo_pkg::cmd_t                cmd
);
    import mjpo_pkg::*;

    logic              started_reg;
    logic              started_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [STEP_W-1:0] this_step;
    logic [SIZE_W-1:0] inc;

    // Tick classification: the first tick after reset or restart initializes.
    always_comb
    begin
        push         = in_valid && !in_full;
        this_step    = restart ? '0 : step_reg;
        inc          = {1'b0, this_step} + 7'd1;
        cmd.init     = restart || !started_reg;
        cmd.comm     = comm;
        cmd.size     = size;
        cmd.step     = this_step;
        started_next = started_reg;
        step_next    = step_reg;
        if (push)
        begin
            started_next = 1'b1;
            step_next    = (inc >= size) ? '0 : inc[STEP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            step_reg    <= '0;
        end else begin
            started_reg <= started_next;
            step_reg    <= step_next;
        end
    end

endmodule

>>> src/mjpo_queue.sv
module mjpo_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mjpo_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output mjpo_pkg::cmd_t head
);
    import mjpo_pkg::*;

    cmd_t       mem_reg [QDEPTH];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign full      = (cnt_reg == 2'(QDEPTH));
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = mem_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !not_empty |-> !pop) else $error("queue underflow");
    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count mismatch");

endmodule

>>> src/mjpo_back.sv
module mjpo_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  mjpo_pkg::cmd_t              q_cmd,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [mjpo_pkg::RANK_W-1:0] rank,
    output logic [mjpo_pkg::IDX_W-1:0]  first_index,
    output logic [mjpo_pkg::IDX_W-1:0]  second_index,
    output logic signed [mjpo_pkg::DEST_W-1:0] first_dest,
    output logic signed [mjpo_pkg::DEST_W-1:0] second_dest,
    output logic [mjpo_pkg::STEP_W-1:0] step_number,
    output logic                        last
);
    import mjpo_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_FILL = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_WR   = 3'd4;

    localparam int LOC_DEPTH = 1 << VAL_W;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    cmd_t             cmd_reg;

    logic [VAL_W-1:0] pf_reg [MAX_RANKS];
    logic [VAL_W-1:0] ps_reg [MAX_RANKS];
    logic [VAL_W-1:0] sf_reg [MAX_RANKS];
    logic [VAL_W-1:0] ss_reg [MAX_RANKS];

    // Location table: for each index value, the slot that holds it next step.
    logic [DEST_W-1:0]  loc_mem [LOC_DEPTH];
    logic [LOC_DEPTH-1:0] loc_vld_reg;
    logic [DEST_W-1:0]  loc_a_reg;
    logic [DEST_W-1:0]  loc_b_reg;
    logic               vld_a_reg;
    logic               vld_b_reg;
    logic [VAL_W-1:0]   cur_f_reg;
    logic [VAL_W-1:0]   cur_s_reg;

    logic [SIZE_W-1:0]   n;
    logic [SIZE_W-1:0]   n1;
    logic [SIZE_W-2:0]   n2;
    logic [RANK_W-1:0]   r_upd;
    logic [RANK_W-1:0]   r_fill;
    adv_t                upd_adv;
    adv_t                fill_adv;
    logic [VAL_W-1:0]    fill_val;
    logic [DEST_W-1:0]   fill_code;
    logic [DEST_W-1:0]   rank_p1;
    logic                out_free;
    logic                load;
    logic                is_last;

    always_comb
    begin
        n         = cmd_reg.size;
        n1        = n - 7'd1;
        n2        = n[SIZE_W-1:1];
        r_upd     = cnt_reg[RANK_W-1:0];
        r_fill    = cnt_reg[RANK_W:1];
        upd_adv   = advance(pf_reg[r_upd], ps_reg[r_upd], sf_reg[r_upd], ss_reg[r_upd],
                            n1, n2);
        fill_adv  = advance(pf_reg[r_fill], ps_reg[r_fill], sf_reg[r_fill],
                            ss_reg[r_fill], n1, n2);
        fill_val  = cnt_reg[0] ? fill_adv.ps : fill_adv.pf;
        rank_p1   = {{(DEST_W-RANK_W){1'b0}}, r_fill} + 7'd1;
        fill_code = cnt_reg[0] ? rank_p1 : (7'd0 - rank_p1);
        out_free  = !out_valid || !out_stall;
        is_last   = (cnt_reg == {1'b0, n2} - 7'd1);
        load      = (state_reg == ST_WR) && out_free;
        pop       = (state_reg == ST_IDLE) && q_valid;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_UPD;
                    cnt_next   = '0;
                end
            end
            ST_UPD:
            begin
                if (is_last)
                begin
                    state_next = cmd_reg.comm ? ST_FILL : ST_RD;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_FILL:
            begin
                if (cnt_reg == n1)
                begin
                    state_next = ST_RD;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            ST_RD:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                if (out_free)
                begin
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_RD;
                        cnt_next   = cnt_reg + 7'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            out_valid   <= 1'b0;
            loc_vld_reg <= '0;
            for (int i = 0; i < MAX_RANKS; i++)
            begin
                pf_reg[i] <= '0;
                ps_reg[i] <= '0;
                sf_reg[i] <= '0;
                ss_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (load)
            begin
                out_valid <= 1'b1;
            end else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
            if (pop)
            begin
                loc_vld_reg <= '0;
            end else if (state_reg == ST_FILL)
            begin
                loc_vld_reg[fill_val] <= 1'b1;
            end
            if (state_reg == ST_UPD)
            begin
                if (cmd_reg.init)
                begin
                    pf_reg[r_upd] <= {{(VAL_W-RANK_W){1'b0}}, r_upd};
                    sf_reg[r_upd] <= {{(VAL_W-RANK_W){1'b0}}, r_upd};
                    ps_reg[r_upd] <= {1'b0, n1} - {{(VAL_W-RANK_W){1'b0}}, r_upd};
                    ss_reg[r_upd] <= {1'b0, n1} - {{(VAL_W-RANK_W){1'b0}}, r_upd};
                end else begin
                    pf_reg[r_upd] <= upd_adv.pf;
                    ps_reg[r_upd] <= upd_adv.ps;
                    sf_reg[r_upd] <= upd_adv.sf;
                    ss_reg[r_upd] <= upd_adv.ss;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (state_reg == ST_FILL)
        begin
            loc_mem[fill_val] <= fill_code;
        end
        if (state_reg == ST_RD)
        begin
            cur_f_reg <= pf_reg[r_upd];
            cur_s_reg <= ps_reg[r_upd];
            loc_a_reg <= loc_mem[pf_reg[r_upd]];
            loc_b_reg <= loc_mem[ps_reg[r_upd]];
            vld_a_reg <= loc_vld_reg[pf_reg[r_upd]];
            vld_b_reg <= loc_vld_reg[ps_reg[r_upd]];
        end
        if (load)
        begin
            rank         <= r_upd;
            first_index  <= cur_f_reg[IDX_W-1:0];
            second_index <= cur_s_reg[IDX_W-1:0];
            first_dest   <= (cmd_reg.comm && vld_a_reg) ? loc_a_reg : '0;
            second_dest  <= (cmd_reg.comm && vld_b_reg) ? loc_b_reg : '0;
            step_number  <= cmd_reg.step;
            last         <= is_last;
        end
    end

    a_upd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) |-> (cnt_reg < {1'b0, n2})) else $error("rank out of range");
    a_fill_needs_comm: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> cmd_reg.comm) else $error("fill without comm");
    a_last_ends_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (load && is_last) |=> (state_reg == ST_IDLE)) else $error("tick did not end");

endmodule

>>> src/modulus_jacobi_pair_ordering_top.sv
// Modified-modulus parallel Jacobi pivot ordering. Each accepted request is one
// step: the block returns n/2 results, one per rank in rank order, each with the
// pivot pair that rank holds, the step number within the sweep, and a last flag
// on the final rank. The first request after reset or with restart set yields
// the pairs (r, n-1-r). With comm_enable set, each index also carries the slot
// that holds it in the following step. A front end classifies requests and
// queues up to two of them; the back end handles one request at a time. A step
// takes the request from the queue, updates the rank registers one rank at a
// time, with comm enabled fills the 256-entry location table one slot per
// cycle, and then for each result reads that table and loads the output
// register, waiting while the output side stalls. Configuration is written
// through a separate port that is always ready and must only be used while
// idle.
module modulus_jacobi_pair_ordering_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [mjpo_pkg::SIZE_W-1:0]        cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               restart,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [mjpo_pkg::RANK_W-1:0]        rank,
    output logic [mjpo_pkg::IDX_W-1:0]         first_index,
    output logic [mjpo_pkg::IDX_W-1:0]         second_index,
    output logic signed [mjpo_pkg::DEST_W-1:0] first_dest,
    output logic signed [mjpo_pkg::DEST_W-1:0] second_dest,
    output logic [mjpo_pkg::STEP_W-1:0]        step_number,
    output logic                               last
);
    import mjpo_pkg::*;

    logic [SIZE_W-1:0] size_reg;
    logic              comm_reg;
    logic [SIZE_W-1:0] n_eff;
    logic              push;
    logic              full;
    logic              q_valid;
    logic              pop;
    cmd_t              push_cmd;
    cmd_t              head;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;

    // The matrix order is forced even and clamped to the supported range.
    always_comb
    begin
        n_eff = {size_reg[SIZE_W-1:1], 1'b0};
        if (n_eff < 7'd2)
        begin
            n_eff = 7'd2;
        end else if (n_eff > 7'(MAX_SIZE))
        begin
            n_eff = 7'(MAX_SIZE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= 7'(MAX_SIZE);
            comm_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MATRIX_SIZE: size_reg <= cfg_data;
                REG_COMM_ENABLE: comm_reg <= cfg_data[0];
                default:         size_reg <= size_reg;
            endcase
        end
    end

    mjpo_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_full  (full),
        .restart  (restart),
        .size     (n_eff),
        .comm     (comm_reg),
        .push     (push),
        .cmd      (push_cmd)
    );

    mjpo_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (full),
        .not_empty (q_valid),
        .head      (head)
    );

    mjpo_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .rank         (rank),
        .first_index  (first_index),
        .second_index (second_index),
        .first_dest   (first_dest),
        .second_dest  (second_dest),
        .step_number  (step_number),
        .last         (last)
    );

endmodule
